[sv/irigb_pkg.sv]
// Package with constants, types and lookup functions of the IRIG-B pulse frame decoder.
package irigb_pkg;

	localparam int FRAME_LEN      = 100;
	localparam int MARKER_SPACING = 10;
	localparam int POS_W          = 7;
	localparam int WIDTH_W        = 8;
	localparam int CFG_INDEX_W    = 2;
	localparam int ACC_W          = 8;
	localparam int DAY_W          = 9;
	localparam int TDATA_OUT_W    = 48;
	localparam int TUSER_OUT_W    = 3;

	localparam logic [WIDTH_W-1:0] ZERO_LIMIT_RST = 8'd3;
	localparam logic [WIDTH_W-1:0] ONE_LIMIT_RST  = 8'd6;
	localparam logic [WIDTH_W-1:0] MARKER_MIN_RST = 8'd7;

	typedef enum logic [1:0] {
		SYM_ZERO    = 2'd0,
		SYM_ONE     = 2'd1,
		SYM_MARKER  = 2'd2,
		SYM_IGNORED = 2'd3
	} sym_class_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_ZERO_LIMIT = 2'd0,
		CFG_ONE_LIMIT  = 2'd1,
		CFG_MARKER_MIN = 2'd2,
		CFG_UNUSED     = 2'd3
	} cfg_index_t;

	localparam logic [ACC_W-1:0] BCD2_W [0:8] = '{
		8'd1, 8'd2, 8'd4, 8'd8, 8'd0, 8'd10, 8'd20, 8'd40, 8'd80
	};

	localparam logic [DAY_W-1:0] BCD3_W [0:13] = '{
		9'd1, 9'd2, 9'd4, 9'd8, 9'd0, 9'd10, 9'd20, 9'd40, 9'd80,
		9'd0, 9'd100, 9'd200, 9'd0, 9'd0
	};

	function automatic logic [ACC_W-1:0] bcd2_weight(logic [3:0] idx);
		logic [ACC_W-1:0] w;
		w = '0;
		if (idx <= 4'd8) begin
			w = BCD2_W[idx];
		end
		return w;
	endfunction

	function automatic logic [DAY_W-1:0] bcd3_weight(logic [3:0] idx);
		logic [DAY_W-1:0] w;
		w = '0;
		if (idx <= 4'd13) begin
			w = BCD3_W[idx];
		end
		return w;
	endfunction

	// True at position 0 and at every position one before a multiple of the spacing.
	function automatic logic is_marker_pos(logic [POS_W-1:0] pos);
		logic hit;
		hit = (pos == '0);
		for (int k = 0; k * MARKER_SPACING + MARKER_SPACING - 1 < (1 << POS_W); k++) begin
			if (pos == POS_W'(k * MARKER_SPACING + MARKER_SPACING - 1)) begin
				hit = 1'b1;
			end
		end
		return hit;
	endfunction

endpackage

[sv/irig_b_pulse_frame_decoder_core.sv]
// Top level of the IRIG-B pulse frame decoder: classify, accumulate and report frames.
//
//  Channel   Direction  Handshake            Payload
//  s_*       in         s_tvalid/s_tready    s_tdata: pulse_width_ms
//  m_*       out        m_tvalid/m_tready    m_tdata: five time values; m_tlast: frame done;
//                                            m_tuser: class, frame valid
//  cfg_*     in         cfg_valid/cfg_ready  cfg_index, cfg_data: threshold registers
//
// Each item is classified and the frame state updated at the edge that accepts it, and the
// result appears in the output register on the next cycle.
// One item per cycle is sustained while m_tready stays high; the single output register sets the figure.
// The input is stalled only while the output register holds a result not yet taken.
// Reset clears the frame state and loads the default thresholds; no clearing pass is needed.
module irig_b_pulse_frame_decoder_core
	import irigb_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [WIDTH_W-1:0]       s_tdata,   // [7:0] pulse_width_ms
	output logic                     m_tvalid,
	input  logic                     m_tready,
	// [7:0] seconds_value, [15:8] minutes_value, [23:16] hours_value,
	// [32:24] day_value, [40:33] year_value, [47:41] zero
	output logic [TDATA_OUT_W-1:0]   m_tdata,
	output logic                     m_tlast,
	// [1:0] symbol_class, [2] frame_valid
	output logic [TUSER_OUT_W-1:0]   m_tuser,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_INDEX_W-1:0]   cfg_index,
	input  logic [WIDTH_W-1:0]       cfg_data
);

	logic [WIDTH_W-1:0] zero_limit_q, one_limit_q, marker_min_q;
	logic               prev_marker_q;
	logic [POS_W-1:0]   pos_q;
	logic [ACC_W-1:0]   sec_q, min_q, hour_q, year_q;
	logic [DAY_W-1:0]   day_q;
	logic               markers_ok_q;
	logic               m_valid_q;
	logic [TDATA_OUT_W-1:0] m_data_q;
	logic               m_last_q;
	logic [TUSER_OUT_W-1:0] m_user_q;

	logic               s_accept;
	sym_class_t         cls;
	logic               restart;
	logic [POS_W-1:0]   pos;
	logic [POS_W-1:0]   off_sec, off_min, off_hour, off_day, off_year;
	logic               done;
	logic               prev_marker_nxt;
	logic [POS_W-1:0]   pos_nxt;
	logic [ACC_W-1:0]   sec_nxt, min_nxt, hour_nxt, year_nxt;
	logic [DAY_W-1:0]   day_nxt;
	logic               markers_ok_nxt;
	logic [ACC_W-1:0]   sec_acc, min_acc, hour_acc, year_acc;
	logic [DAY_W-1:0]   day_acc;
	logic               mok_acc;
	logic [TDATA_OUT_W-1:0] res_data;
	logic               res_last;
	logic [TUSER_OUT_W-1:0] res_user;

	assign s_tready  = !m_valid_q || m_tready;
	assign s_accept  = s_tvalid && s_tready;
	assign m_tvalid  = m_valid_q;
	assign m_tdata   = m_data_q;
	assign m_tlast   = m_last_q;
	assign m_tuser   = m_user_q;
	assign cfg_ready = 1'b1;

	always_comb begin
		cls = SYM_IGNORED;
		if (s_tdata < zero_limit_q) begin
			cls = SYM_ZERO;
		end else if (s_tdata < one_limit_q) begin
			cls = SYM_ONE;
		end
		if (s_tdata >= marker_min_q) begin
			cls = SYM_MARKER;
		end
	end

	always_comb begin
		restart  = (cls == SYM_MARKER) && prev_marker_q;
		pos      = restart ? '0 : pos_q;
		sec_acc  = restart ? '0 : sec_q;
		min_acc  = restart ? '0 : min_q;
		hour_acc = restart ? '0 : hour_q;
		day_acc  = restart ? '0 : day_q;
		year_acc = restart ? '0 : year_q;
		mok_acc  = restart ? 1'b1 : markers_ok_q;
		off_sec  = pos - POS_W'(1);
		off_min  = pos - POS_W'(10);
		off_hour = pos - POS_W'(20);
		off_day  = pos - POS_W'(30);
		off_year = pos - POS_W'(50);

		if (is_marker_pos(pos)) begin
			if (cls != SYM_MARKER) begin
				mok_acc = 1'b0;
			end
		end else if (cls == SYM_ONE) begin
			if (pos >= POS_W'(1) && pos <= POS_W'(8)) begin
				sec_acc = sec_acc + bcd2_weight(off_sec[3:0]);
			end else if (pos >= POS_W'(10) && pos <= POS_W'(18)) begin
				min_acc = min_acc + bcd2_weight(off_min[3:0]);
			end else if (pos >= POS_W'(20) && pos <= POS_W'(28)) begin
				hour_acc = hour_acc + bcd2_weight(off_hour[3:0]);
			end else if (pos >= POS_W'(30) && pos <= POS_W'(43)) begin
				day_acc = day_acc + bcd3_weight(off_day[3:0]);
			end else if (pos >= POS_W'(50) && pos <= POS_W'(58)) begin
				year_acc = year_acc + bcd2_weight(off_year[3:0]);
			end
		end

		done = ({1'b0, pos} + (POS_W+1)'(1)) >= (POS_W+1)'(FRAME_LEN);

		prev_marker_nxt = prev_marker_q;
		pos_nxt         = pos_q;
		sec_nxt         = sec_q;
		min_nxt         = min_q;
		hour_nxt        = hour_q;
		day_nxt         = day_q;
		year_nxt        = year_q;
		markers_ok_nxt  = markers_ok_q;
		res_data        = '0;
		res_last        = 1'b0;
		res_user        = {1'b0, cls};

		if (cls != SYM_IGNORED) begin
			prev_marker_nxt = (cls == SYM_MARKER);
			if (done) begin
				res_user       = {mok_acc, cls};
				res_last       = 1'b1;
				res_data       = {7'd0, year_acc, day_acc, hour_acc, min_acc, sec_acc};
				pos_nxt        = '0;
				sec_nxt        = '0;
				min_nxt        = '0;
				hour_nxt       = '0;
				day_nxt        = '0;
				year_nxt       = '0;
				markers_ok_nxt = 1'b1;
			end else begin
				pos_nxt        = pos + POS_W'(1);
				sec_nxt        = sec_acc;
				min_nxt        = min_acc;
				hour_nxt       = hour_acc;
				day_nxt        = day_acc;
				year_nxt       = year_acc;
				markers_ok_nxt = mok_acc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_limit_q <= ZERO_LIMIT_RST;
			one_limit_q  <= ONE_LIMIT_RST;
			marker_min_q <= MARKER_MIN_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_ZERO_LIMIT: zero_limit_q <= cfg_data;
				CFG_ONE_LIMIT:  one_limit_q  <= cfg_data;
				CFG_MARKER_MIN: marker_min_q <= cfg_data;
				CFG_UNUSED: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_marker_q <= 1'b0;
			pos_q         <= '0;
			sec_q         <= '0;
			min_q         <= '0;
			hour_q        <= '0;
			day_q         <= '0;
			year_q        <= '0;
			markers_ok_q  <= 1'b1;
		end else if (s_accept) begin
			prev_marker_q <= prev_marker_nxt;
			pos_q         <= pos_nxt;
			sec_q         <= sec_nxt;
			min_q         <= min_nxt;
			hour_q        <= hour_nxt;
			day_q         <= day_nxt;
			year_q        <= year_nxt;
			markers_ok_q  <= markers_ok_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (s_accept) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			m_data_q <= res_data;
			m_last_q <= res_last;
			m_user_q <= res_user;
		end
	end

`ifndef SYNTHESIS
	a_pos_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q < POS_W'(FRAME_LEN))
		else $error("frame position reached the frame length");

	a_ignored_keeps_state: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept && cls == SYM_IGNORED |=> $stable(pos_q) && $stable(prev_marker_q)
			&& $stable(markers_ok_q))
		else $error("ignored item changed the frame state");

	a_done_not_ignored: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && m_last_q |-> m_user_q[1:0] != SYM_IGNORED)
		else $error("frame completed by an ignored item");

	a_valid_needs_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && !m_last_q |-> m_user_q[2] == 1'b0 && m_data_q == '0)
		else $error("frame fields reported without a completed frame");

	a_done_clears_pos: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept && cls != SYM_IGNORED && done |=> pos_q == '0 && markers_ok_q)
		else $error("frame state not cleared after a completed frame");
`endif

endmodule

[sim/irig_b_pulse_frame_decoder_core_tb.sv]
// Self-checking testbench for the IRIG-B pulse frame decoder core.
`timescale 1ns / 100ps

module irig_b_pulse_frame_decoder_core_tb
	import irigb_pkg::*;
;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 300;

	typedef struct {
		sym_class_t       cls;
		bit               done;
		bit               valid;
		bit [ACC_W-1:0]   sec;
		bit [ACC_W-1:0]   min;
		bit [ACC_W-1:0]   hour;
		bit [DAY_W-1:0]   day;
		bit [ACC_W-1:0]   year;
	} decoded_t;

	class frame_decode_tracker;
		bit [WIDTH_W-1:0] zero_limit = ZERO_LIMIT_RST;
		bit [WIDTH_W-1:0] one_limit = ONE_LIMIT_RST;
		bit [WIDTH_W-1:0] marker_min = MARKER_MIN_RST;
		bit               last_was_marker;
		bit [POS_W-1:0]   slot;
		bit [ACC_W-1:0]   sec_sum;
		bit [ACC_W-1:0]   min_sum;
		bit [ACC_W-1:0]   hour_sum;
		bit [DAY_W-1:0]   day_sum;
		bit [ACC_W-1:0]   year_sum;
		bit               markers_seen_ok = 1'b1;
		int               two_digit [0:8] = '{1, 2, 4, 8, 0, 10, 20, 40, 80};
		int               three_digit [0:13] = '{1, 2, 4, 8, 0, 10, 20, 40, 80, 0, 100, 200, 0, 0};
		decoded_t         awaited_decodes [$];
		int               mismatch_count;
		int               results_seen;

		function void set_threshold(cfg_index_t idx, bit [WIDTH_W-1:0] value);
			case (idx)
				CFG_ZERO_LIMIT: zero_limit = value;
				CFG_ONE_LIMIT: one_limit = value;
				CFG_MARKER_MIN: marker_min = value;
				default: ;
			endcase
		endfunction

		function sym_class_t classify(bit [WIDTH_W-1:0] w);
			sym_class_t cls;
			cls = SYM_IGNORED;
			if (w < zero_limit) begin
				cls = SYM_ZERO;
			end else if (w < one_limit) begin
				cls = SYM_ONE;
			end
			if (w >= marker_min) begin
				cls = SYM_MARKER;
			end
			return cls;
		endfunction

		function void restart_frame();
			slot = '0;
			sec_sum = '0;
			min_sum = '0;
			hour_sum = '0;
			day_sum = '0;
			year_sum = '0;
			markers_seen_ok = 1'b1;
		endfunction

		function void add_weight(int pos);
			if (pos >= 1 && pos <= 8) begin
				sec_sum = sec_sum + ACC_W'(two_digit[pos - 1]);
			end else if (pos >= 10 && pos <= 18) begin
				min_sum = min_sum + ACC_W'(two_digit[pos - 10]);
			end else if (pos >= 20 && pos <= 28) begin
				hour_sum = hour_sum + ACC_W'(two_digit[pos - 20]);
			end else if (pos >= 30 && pos <= 43) begin
				day_sum = day_sum + DAY_W'(three_digit[pos - 30]);
			end else if (pos >= 50 && pos <= 58) begin
				year_sum = year_sum + ACC_W'(two_digit[pos - 50]);
			end
		endfunction

		function void note_pulse(bit [WIDTH_W-1:0] w);
			decoded_t d;
			int pos;
			d.cls = classify(w);
			d.done = 1'b0;
			d.valid = 1'b0;
			d.sec = '0;
			d.min = '0;
			d.hour = '0;
			d.day = '0;
			d.year = '0;
			if (d.cls != SYM_IGNORED) begin
				if (d.cls == SYM_MARKER && last_was_marker) begin
					restart_frame();
				end
				pos = int'(slot);
				if (pos == 0 || pos % MARKER_SPACING == MARKER_SPACING - 1) begin
					if (d.cls != SYM_MARKER) begin
						markers_seen_ok = 1'b0;
					end
				end else if (d.cls == SYM_ONE) begin
					add_weight(pos);
				end
				last_was_marker = (d.cls == SYM_MARKER);
				slot = POS_W'(pos + 1);
				if (pos + 1 >= FRAME_LEN) begin
					d.done = 1'b1;
					d.valid = markers_seen_ok;
					d.sec = sec_sum;
					d.min = min_sum;
					d.hour = hour_sum;
					d.day = day_sum;
					d.year = year_sum;
					restart_frame();
				end
			end
			awaited_decodes.push_back(d);
		endfunction

		function void compare(string field, int unsigned want, int unsigned got);
			if (want != got) begin
				mismatch_count++;
				if (mismatch_count <= 10) begin
					$display("result %0d: %s expected %0d, got %0d", results_seen, field,
						want, got);
				end
			end
		endfunction

		function void check_decoded(bit [TDATA_OUT_W-1:0] data, bit last,
				bit [TUSER_OUT_W-1:0] user);
			decoded_t e;
			results_seen++;
			if (awaited_decodes.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10) begin
					$display("result %0d: unexpected item, tuser %h tdata %h", results_seen,
						user, data);
				end
				return;
			end
			e = awaited_decodes.pop_front();
			compare("symbol_class", int'(e.cls), user[1:0]);
			compare("frame_done", e.done, last);
			compare("frame_valid", e.valid, user[2]);
			compare("seconds_value", e.sec, data[7:0]);
			compare("minutes_value", e.min, data[15:8]);
			compare("hours_value", e.hour, data[23:16]);
			compare("day_value", e.day, data[32:24]);
			compare("year_value", e.year, data[40:33]);
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [WIDTH_W-1:0]     s_tdata = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [TDATA_OUT_W-1:0] m_tdata;
	logic                   m_tlast;
	logic [TUSER_OUT_W-1:0] m_tuser;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [WIDTH_W-1:0]     cfg_data = '0;

	frame_decode_tracker tracker = new();
	bit src_gapless;
	bit sink_gapless;
	bit hold_request;
	int cycle_count;

	irig_b_pulse_frame_decoder_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("irig_b_pulse_frame_decoder_core_tb: done, errors");
			$finish;
		end
	end

	task automatic send_pulse(input bit [WIDTH_W-1:0] w);
		int gap;
		gap = src_gapless ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= w;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		tracker.note_pulse(w);
		if ($urandom_range(0, 39) == 0) begin
			src_gapless = !src_gapless;
		end
	endtask

	function automatic int pick_width(sym_class_t sym);
		int hits [$];
		for (int w = 0; w < 256; w++) begin
			if (tracker.classify(8'(w)) == sym) begin
				hits.push_back(w);
			end
		end
		if (hits.size() == 0) begin
			return -1;
		end
		return hits[$urandom_range(0, hits.size() - 1)];
	endfunction

	task automatic send_symbol(input sym_class_t sym);
		int w;
		w = pick_width(sym);
		if (w >= 0) begin
			send_pulse(8'(w));
		end
	endtask

	task automatic send_frame(input bit broken, input bit ones_only);
		sym_class_t sym;
		bit prev_marker;
		send_symbol(SYM_MARKER);
		send_symbol(SYM_MARKER);
		prev_marker = 1'b1;
		for (int pos = 1; pos < FRAME_LEN; pos++) begin
			if ($urandom_range(0, 24) == 0) begin
				send_symbol(SYM_IGNORED);
			end
			if (pos % MARKER_SPACING == MARKER_SPACING - 1) begin
				sym = SYM_MARKER;
				if (broken && $urandom_range(0, 3) == 0) begin
					sym = $urandom_range(0, 1) ? SYM_ONE : SYM_ZERO;
				end
			end else begin
				sym = (ones_only || $urandom_range(0, 1)) ? SYM_ONE : SYM_ZERO;
				if (broken && !prev_marker && pos % MARKER_SPACING != MARKER_SPACING - 2 &&
						$urandom_range(0, 9) == 0) begin
					sym = SYM_MARKER;
				end
			end
			send_symbol(sym);
			prev_marker = (sym == SYM_MARKER);
		end
	endtask

	task automatic send_noise(input int count);
		repeat (count) send_pulse(8'($urandom_range(0, 255)));
	endtask

	task automatic write_register(input cfg_index_t idx, input bit [WIDTH_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		tracker.set_threshold(idx, value);
	endtask

	task automatic program_thresholds(input bit [WIDTH_W-1:0] zero_lim,
			input bit [WIDTH_W-1:0] one_lim, input bit [WIDTH_W-1:0] marker_lim);
		write_register(CFG_ZERO_LIMIT, zero_lim);
		write_register(CFG_ONE_LIMIT, one_lim);
		write_register(CFG_MARKER_MIN, marker_lim);
		write_register(CFG_UNUSED, 8'($urandom_range(0, 255)));
		cfg_valid <= 1'b0;
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		while (tracker.awaited_decodes.size() > 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin : result_sink
		int stall;
		wait (arst_n === 1'b1);
		forever begin
			stall = sink_gapless ? 0 : $urandom_range(0, 6);
			if (hold_request) begin
				hold_request = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			tracker.check_decoded(m_tdata, m_tlast, m_tuser);
			if ($urandom_range(0, 39) == 0) begin
				sink_gapless = !sink_gapless;
			end
		end
	end

	initial begin : stimulus
		bit [WIDTH_W-1:0] opening [20];
		opening = '{
			8'd0, 8'd2, 8'd3, 8'd5, 8'd6, 8'd7, 8'd255, 8'd1, 8'd4, 8'd200,
			8'd0, 8'd5, 8'd9, 8'd6, 8'd10, 8'd128, 8'd1, 8'd2, 8'd254, 8'd6
		};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		program_thresholds(ZERO_LIMIT_RST, ONE_LIMIT_RST, MARKER_MIN_RST);
		foreach (opening[i]) send_pulse(opening[i]);
		settle();

		// The sink holds off for a long stretch while this frame keeps the input busy.
		hold_request = 1'b1;
		send_frame(1'b0, 1'b0);
		send_noise(20);
		send_frame(1'b1, 1'b0);
		send_noise(20);
		settle();

		program_thresholds(8'd20, 8'd45, 8'd80);
		send_frame(1'b1, 1'b0);
		send_noise(40);
		settle();

		program_thresholds(8'd255, 8'd255, 8'd255);
		send_frame(1'b0, 1'b0);
		settle();

		program_thresholds(8'd1, 8'd255, 8'd255);
		send_frame(1'b0, 1'b1);
		settle();

		program_thresholds(8'd0, 8'd0, 8'd255);
		send_noise(25);
		settle();

		program_thresholds(8'd255, 8'd0, 8'd0);
		send_noise(25);
		settle();

		repeat (10) @(posedge clk);
		if (tracker.mismatch_count == 0 && tracker.awaited_decodes.size() == 0) begin
			$display("irig_b_pulse_frame_decoder_core_tb: done, clean");
		end else begin
			$display("irig_b_pulse_frame_decoder_core_tb: done, errors");
		end
		$finish;
	end

endmodule
